// ----- hdl/asa_pkg.sv -----
// Package: shared types, codes and constants of the aligned stack allocator.
`timescale 1ns / 1ps
`default_nettype none
package asa_pkg;

  localparam int BUFFER_BYTES = 4096;
  localparam int HDR_AW       = $clog2(BUFFER_BYTES);
  localparam int OFS_W        = 13;
  localparam int PAD_W        = 8;
  localparam int BASE_W       = 7;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 13;

  localparam logic [OFS_W-1:0] LEN_MAX   = OFS_W'(BUFFER_BYTES);
  localparam logic [PAD_W-1:0] ALIGN_CAP = 8'd128;

  localparam logic [1:0] MODE_ALLOC    = 2'd0;
  localparam logic [1:0] MODE_FREE     = 2'd1;
  localparam logic [1:0] MODE_FREE_ALL = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_ROOM = 2'd1;
  localparam logic [1:0] ST_OOB     = 2'd2;
  localparam logic [1:0] ST_IGNORED = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_LENGTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_LOW      = 1'd1;

  typedef struct packed {
    logic [1:0]       mode;
    logic [OFS_W-1:0] size;
    logic [3:0]       align_log2;
    logic [OFS_W-1:0] block_offset_in;
  } asa_in_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [OFS_W-1:0] block_offset;
    logic [OFS_W-1:0] top_offset;
  } asa_out_t;

  // controller -> datapath
  typedef struct packed {
    logic clear;
    logic accept;
    logic exec;
  } asa_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clear_done;
    logic out_full;
  } asa_sts_t;

endpackage
`default_nettype wire

// ----- hdl/asa_ctrl.sv -----
// Controller: header-store clear sweep, transaction accept and execute sequencing.
`timescale 1ns / 1ps
`default_nettype none
module asa_ctrl import asa_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire logic     out_stall,
  input  wire asa_sts_t sts,
  output asa_cmd_t      cmd
);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       can_take;

  // output register is free now or empties at this edge
  assign can_take = (state_r == S_IDLE) && !(sts.out_full && out_stall);
  assign in_stall = !can_take;

  always_comb begin
    cmd.clear  = (state_r == S_CLEAR);
    cmd.accept = can_take && in_valid;
    cmd.exec   = (state_r == S_EXEC);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (sts.clear_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (cmd.accept) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/asa_dp.sv -----
// Datapath: config registers, stack top, header store and result register.
`timescale 1ns / 1ps
`default_nettype none
module asa_dp import asa_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire asa_cmd_t              cmd,
  output asa_sts_t                   sts,
  input  wire asa_in_t               in_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output asa_out_t                   out_data
);

  logic [OFS_W-1:0]  buf_len_r;
  logic [BASE_W-1:0] base_r;
  logic [OFS_W-1:0]  top_r, top_nxt;
  asa_in_t           op_r;
  logic [HDR_AW-1:0] clr_cnt_r;
  logic [PAD_W-1:0]  hdr_mem [BUFFER_BYTES];
  logic [PAD_W-1:0]  rdata_r;
  logic              out_valid_r;
  asa_out_t          out_data_r, res;

  logic [OFS_W-1:0]  len;
  logic [PAD_W-1:0]  align_a, pad;
  logic [BASE_W-1:0] addr_lo, rem;
  logic [OFS_W+1:0]  need;
  logic [OFS_W-1:0]  blk, hdr, off;
  logic              fits;
  logic              mem_we;
  logic [HDR_AW-1:0] mem_wa, mem_ra;
  logic [PAD_W-1:0]  mem_wd;

  assign len = (buf_len_r > LEN_MAX) ? LEN_MAX : buf_len_r;
  assign off = op_r.block_offset_in;

  // alignment padding: always at least one byte for the header
  always_comb begin
    align_a = (op_r.align_log2 > 4'd7) ? ALIGN_CAP : (8'd1 << op_r.align_log2[2:0]);
    addr_lo = base_r + top_r[BASE_W-1:0];
    rem     = addr_lo & (align_a[BASE_W-1:0] - 7'd1);
    pad     = (rem != '0) ? (align_a - {1'b0, rem}) : align_a;
    need    = {2'b00, top_r} + {7'd0, pad} + {2'b00, op_r.size};
    fits    = (need <= {2'b00, len});
    blk     = top_r + {5'd0, pad};
    hdr     = blk - 13'd1;
  end

  always_comb begin
    res     = '0;
    top_nxt = top_r;
    case (op_r.mode)
      MODE_ALLOC: begin
        if (!fits) begin
          res.status = ST_NO_ROOM;
        end else begin
          res.block_offset = blk;
          top_nxt          = need[OFS_W-1:0];
        end
      end
      MODE_FREE: begin
        if (off == '0 || off >= len) begin
          res.status = ST_OOB;
        end else if (off >= top_r) begin
          res.status = ST_IGNORED;
        end else begin
          top_nxt = ({5'd0, rdata_r} > off) ? '0 : (off - {5'd0, rdata_r});
        end
      end
      MODE_FREE_ALL: begin
        top_nxt = '0;
      end
      default: begin
      end
    endcase
    res.top_offset = top_nxt;
  end

  assign mem_we = cmd.clear || (cmd.exec && op_r.mode == MODE_ALLOC && fits);
  assign mem_wa = cmd.clear ? clr_cnt_r : hdr[HDR_AW-1:0];
  assign mem_wd = cmd.clear ? '0 : pad;
  assign mem_ra = in_data.block_offset_in[HDR_AW-1:0] - 12'd1;

  always_ff @(posedge clk) begin
    if (mem_we) hdr_mem[mem_wa] <= mem_wd;
    if (cmd.accept) rdata_r <= hdr_mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) op_r <= in_data;
    if (cmd.exec) out_data_r <= res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_len_r   <= LEN_MAX;
      base_r      <= '0;
      top_r       <= '0;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == CFG_BUFFER_LENGTH) buf_len_r <= cfg_data;
      if (cfg_we && cfg_index == CFG_BASE_LOW) base_r <= cfg_data[BASE_W-1:0];
      if (cmd.clear) clr_cnt_r <= clr_cnt_r + 12'd1;
      if (cmd.exec) begin
        top_r       <= top_nxt;
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.clear_done = (clr_cnt_r == '1);
  assign sts.out_full   = out_valid_r;
  assign out_valid      = out_valid_r;
  assign out_data       = out_data_r;

endmodule
`default_nettype wire

// ----- hdl/aligned_stack_allocator_unit.sv -----
// Top level: aligned LIFO stack allocator with one-byte padding headers.
`timescale 1ns / 1ps
`default_nettype none
// Each transaction is accepted in S_IDLE and executed in S_EXEC: the accept
// cycle issues the synchronous read of the header store, and the execute cycle
// computes the new stack top, writes the allocate's header byte and loads the
// result register; the next transaction is taken in the cycle after that, or in
// the same cycle the previous result leaves. After reset the 4096-entry header
// store is zeroed by a sweep of its entries, during which in_stall stays high;
// configuration writes are taken throughout.
module aligned_stack_allocator_unit import asa_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire asa_in_t               in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output asa_out_t                   out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  asa_cmd_t cmd;
  asa_sts_t sts;

  asa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  asa_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  a_exec_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> out_valid)
    else $error("executed transaction did not reach the result register");

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |-> in_stall)
    else $error("input taken during header clear sweep");

  a_top_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.top_offset <= LEN_MAX))
    else $error("stack top beyond buffer");

  a_blk_only_on_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != ST_OK) |-> (out_data.block_offset == '0))
    else $error("block offset set on failed transaction");

endmodule
`default_nettype wire
